// ===== hw/rtl/srp_pkg.sv =====
// Shared types and constants for the stepper trapezoid ramp block.
// Used by srp_ctrl, srp_dpath, srp_div and stepper_trapezoid_ramp_top.
`default_nettype none
package srp_pkg;

  localparam int DataW = 32;
  localparam int DelayW = 16;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 24;
  localparam int OutW = 56;

  localparam logic [1:0] PH_STOP  = 2'd0;
  localparam logic [1:0] PH_ACCEL = 2'd1;
  localparam logic [1:0] PH_DECEL = 2'd2;
  localparam logic [1:0] PH_RUN   = 2'd3;

  localparam logic [CfgAddrW-1:0] REG_FIRST_DELAY = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_TOP_DELAY   = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_STEPS_TOP   = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_ACCEL       = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_DECEL       = 3'd4;

  localparam logic       CMD_START = 1'b0;
  localparam logic [DelayW-1:0] ONE_STEP_DELAY = 16'd1000;

  typedef struct packed {
    logic latch_in;
    logic mul1;
    logic div1_go;
    logic lim_cap;
    logic mul2;
    logic div2_go;
    logic commit_start;
    logic tay_go;
    logic commit_ev;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/srp_div.sv =====
// Iterative 32-bit unsigned restoring divider, one quotient bit per cycle.
// Divisor zero gives an all-ones quotient. Depends on srp_pkg.
`default_nettype none
module srp_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [srp_pkg::DataW-1:0] dividend,
  input  wire logic [srp_pkg::DataW-1:0] divisor,
  output logic                          done,
  output logic [srp_pkg::DataW-1:0]     quotient,
  output logic [srp_pkg::DataW-1:0]     remainder
);
  import srp_pkg::*;

  logic [DataW-1:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  always_comb begin
    trial = {rem_r, quo_r[DataW-1]};
    diff = trial - {1'b0, dvs_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      if (!diff[DataW]) begin
        rem_nxt = diff[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done = done_r;
  assign quotient = quo_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

// ===== hw/rtl/srp_ctrl.sv =====
// Sequencing state machine for the stepper ramp: handshakes and datapath commands.
// Depends on srp_pkg.
`default_nettype none
module srp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_cmd,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire srp_pkg::sts_t  sts,
  output srp_pkg::cmd_t       cmd
);
  import srp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_DIV1 = 4'd2;
  localparam logic [3:0] S_WT1  = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_DIV2 = 4'd5;
  localparam logic [3:0] S_WT2  = 4'd6;
  localparam logic [3:0] S_CST  = 4'd7;
  localparam logic [3:0] S_TGO  = 4'd8;
  localparam logic [3:0] S_TWT  = 4'd9;
  localparam logic [3:0] S_CEV  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       slot_free;

  assign slot_free = !ov_r || out_ready;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r && !out_ready;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.latch_in = 1'b1;
        if (in_cmd == CMD_START) state_nxt = S_MUL1;
        else if (sts.need_div) state_nxt = S_TGO;
        else state_nxt = S_CEV;
      end
      S_MUL1: begin cmd.mul1 = 1'b1; state_nxt = S_DIV1; end
      S_DIV1: begin cmd.div1_go = 1'b1; state_nxt = S_WT1; end
      S_WT1: if (sts.div_done) begin
        cmd.lim_cap = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin cmd.mul2 = 1'b1; state_nxt = S_DIV2; end
      S_DIV2: begin cmd.div2_go = 1'b1; state_nxt = S_WT2; end
      S_WT2: if (sts.div_done) state_nxt = S_CST;
      S_CST: begin cmd.commit_start = 1'b1; state_nxt = S_OUT; end
      S_TGO: begin cmd.tay_go = 1'b1; state_nxt = S_TWT; end
      S_TWT: if (sts.div_done) state_nxt = S_CEV;
      S_CEV: begin cmd.commit_ev = 1'b1; state_nxt = S_OUT; end
      S_OUT: if (slot_free) begin
        cmd.out_load = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
endmodule
`default_nettype wire

// ===== hw/rtl/srp_dpath.sv =====
// Ramp datapath: configuration, move state, multiplies, Taylor step, result register.
// Depends on srp_pkg and srp_div.
`default_nettype none
module srp_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [srp_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [srp_pkg::CfgDataW-1:0]  cfg_wdata,
  input  wire logic [srp_pkg::DataW-1:0]     in_steps,
  input  wire srp_pkg::cmd_t                 cmd,
  output srp_pkg::sts_t                      sts,
  output logic [srp_pkg::OutW-1:0]           out_data
);
  import srp_pkg::*;

  logic [DelayW-1:0] first_r, tsd_r, acc_r, dec_r;
  logic [23:0]       stts_r;
  logic [1:0]        phase_r, phase_nxt;
  logic              dir_r, dir_nxt, half_r, half_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [DelayW-1:0] cur_r, cur_nxt, last_r, last_nxt, cruise_r, cruise_nxt;
  logic [DataW-1:0]  idx_r, idx_nxt, off_r, off_nxt, dp_r, dp_nxt, steps_r, steps_nxt;
  logic [DataW-1:0]  rem_r, rem_nxt, pos_r, pos_nxt;
  logic [DataW-1:0]  raw_r, prod_r, lim_r;
  logic              na_r, nb_r, took_r, took_nxt;
  logic [DelayW-1:0] ivl_r, ivl_nxt;
  logic [OutW-1:0]   out_r;

  logic [DataW-1:0]  mag, top, lim1, off_t, idx_inc, tay_a, tay_b, div_a, div_b;
  logic [DataW-1:0]  quo, rmd, tq, tr, steps_inc, pos_inc;
  logic [DelayW-1:0] nd;
  logic              div_go, div_done;
  logic [47:0]       mul_a;
  logic [39:0]       mul_b;

  assign mag = raw_r[DataW-1] ? -raw_r : raw_r;
  assign top = (stts_r == '0) ? 32'd1 : {8'd0, stts_r};
  assign mul_a = {16'd0, mag} * {32'd0, dec_r};
  assign mul_b = {8'd0, top} * {24'd0, acc_r};
  assign idx_inc = idx_r + 32'd1;
  assign tay_a = {15'd0, cur_r, 1'b0} + rem_r;
  assign tay_b = {idx_inc[DataW-3:0], 2'b00} + 32'd1;

  always_comb begin
    if (cmd.tay_go) begin
      div_a = tay_a[DataW-1] ? -tay_a : tay_a;
      div_b = tay_b[DataW-1] ? -tay_b : tay_b;
    end else if (cmd.div1_go) begin
      div_a = prod_r;
      div_b = {15'd0, {1'b0, acc_r} + {1'b0, dec_r}};
    end else begin
      div_a = prod_r;
      div_b = {16'd0, dec_r};
    end
  end

  assign div_go = cmd.tay_go | cmd.div1_go | cmd.div2_go;

  srp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(quo), .remainder(rmd)
  );

  assign tq = (na_r ^ nb_r) ? -quo : quo;
  assign tr = na_r ? -rmd : rmd;
  assign nd = cur_r - tq[DelayW-1:0];
  assign steps_inc = steps_r + 32'd1;
  assign pos_inc = pos_r + (dir_r ? 32'hFFFF_FFFF : 32'd1);
  assign lim1 = (lim_r == '0) ? 32'd1 : lim_r;
  assign off_t = (lim1 <= top) ? lim1 - mag : -quo;

  always_comb begin
    phase_nxt = phase_r; dir_nxt = dir_r; half_nxt = half_r; busy_nxt = busy_r;
    done_nxt = done_r; cur_nxt = cur_r; last_nxt = last_r; cruise_nxt = cruise_r;
    idx_nxt = idx_r; off_nxt = off_r; dp_nxt = dp_r; steps_nxt = steps_r;
    rem_nxt = rem_r; pos_nxt = pos_r; took_nxt = took_r; ivl_nxt = ivl_r;
    if (cmd.tay_go) idx_nxt = idx_inc;
    if (cmd.commit_start) begin
      done_nxt = 1'b0;
      busy_nxt = 1'b1;
      dir_nxt = raw_r[DataW-1];
      took_nxt = 1'b0;
      if (mag == 32'd1) begin
        idx_nxt = '1;
        phase_nxt = PH_DECEL;
        cur_nxt = ONE_STEP_DELAY;
      end else if (mag != '0) begin
        cruise_nxt = tsd_r;
        off_nxt = (off_t == '0) ? '1 : off_t;
        dp_nxt = mag + ((off_t == '0) ? '1 : off_t);
        if (first_r <= tsd_r) begin
          cur_nxt = tsd_r;
          phase_nxt = PH_RUN;
        end else begin
          cur_nxt = first_r;
          phase_nxt = PH_ACCEL;
        end
        idx_nxt = '0;
      end
      ivl_nxt = cur_nxt;
    end
    if (cmd.commit_ev) begin
      half_nxt = ~half_r;
      ivl_nxt = cur_r;
      took_nxt = 1'b0;
      if (half_r) begin
        case (phase_r)
          PH_STOP: begin
            steps_nxt = '0;
            rem_nxt = '0;
            busy_nxt = 1'b0;
            cur_nxt = '0;
          end
          PH_ACCEL: begin
            steps_nxt = steps_inc; pos_nxt = pos_inc; took_nxt = 1'b1;
            rem_nxt = tr;
            cur_nxt = nd;
            if (steps_inc >= dp_r) begin
              idx_nxt = off_r;
              phase_nxt = PH_DECEL;
            end else if (nd <= cruise_r) begin
              last_nxt = nd;
              cur_nxt = cruise_r;
              rem_nxt = '0;
              phase_nxt = PH_RUN;
            end
          end
          PH_RUN: begin
            steps_nxt = steps_inc; pos_nxt = pos_inc; took_nxt = 1'b1;
            cur_nxt = cruise_r;
            if (steps_inc >= dp_r) begin
              idx_nxt = off_r;
              cur_nxt = last_r;
              phase_nxt = PH_DECEL;
            end
          end
          default: begin
            steps_nxt = steps_inc; pos_nxt = pos_inc; took_nxt = 1'b1;
            rem_nxt = tr;
            cur_nxt = nd;
            if (!idx_r[DataW-1]) begin
              phase_nxt = PH_STOP;
              done_nxt = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 16'd1000; tsd_r <= 16'd100; stts_r <= 24'd1;
      acc_r <= 16'd100; dec_r <= 16'd100;
      phase_r <= PH_STOP; dir_r <= 1'b0; half_r <= 1'b0; busy_r <= 1'b0; done_r <= 1'b0;
      cur_r <= '0; last_r <= '0; cruise_r <= '0; idx_r <= '0; off_r <= '0; dp_r <= '0;
      steps_r <= '0; rem_r <= '0; pos_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FIRST_DELAY: first_r <= cfg_wdata[DelayW-1:0];
          REG_TOP_DELAY:   tsd_r <= cfg_wdata[DelayW-1:0];
          REG_STEPS_TOP:   stts_r <= cfg_wdata;
          REG_ACCEL:       acc_r <= cfg_wdata[DelayW-1:0];
          REG_DECEL:       dec_r <= cfg_wdata[DelayW-1:0];
          default: ;
        endcase
      end
      phase_r <= phase_nxt; dir_r <= dir_nxt; half_r <= half_nxt; busy_r <= busy_nxt;
      done_r <= done_nxt; cur_r <= cur_nxt; last_r <= last_nxt; cruise_r <= cruise_nxt;
      idx_r <= idx_nxt; off_r <= off_nxt; dp_r <= dp_nxt; steps_r <= steps_nxt;
      rem_r <= rem_nxt; pos_r <= pos_nxt;
    end
    took_r <= took_nxt;
    ivl_r <= ivl_nxt;
    if (cmd.latch_in) raw_r <= in_steps;
    if (cmd.mul1) prod_r <= mul_a[DataW-1:0];
    if (cmd.mul2) prod_r <= mul_b[DataW-1:0];
    if (cmd.lim_cap) lim_r <= quo;
    if (cmd.tay_go) begin
      na_r <= tay_a[DataW-1];
      nb_r <= tay_b[DataW-1];
    end
    if (cmd.out_load) out_r <= {4'd0, dir_r, done_r, busy_r, pos_r, took_r, ivl_r};
  end

  assign sts.need_div = half_r && (phase_r == PH_ACCEL || phase_r == PH_DECEL);
  assign sts.div_done = div_done;
  assign out_data = out_r;
endmodule
`default_nettype wire

// ===== hw/rtl/stepper_trapezoid_ramp_top.sv =====
// Trapezoidal stepper ramp generator: start and timer-event items in, one result per item.
// A start item waits twice on the 32-step divider for the decel point; a second event in the
// accel or decel phase waits once on the bit-serial divider for the next step delay; other events
// need no divide. The next item is accepted while a result waits in the output register.
// Depends on srp_pkg, srp_ctrl, srp_dpath, srp_div.
`default_nettype none
module stepper_trapezoid_ramp_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [srp_pkg::DataW-1:0]     in_tdata,   // move_steps
  input  wire logic [0:0]                    in_tuser,   // command
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // compare_interval[15:0], step_taken, position[31:0], moving, move_finished, direction
  output logic [srp_pkg::OutW-1:0]           out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [srp_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [srp_pkg::CfgDataW-1:0]  cfg_wdata
);
  import srp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_cmd(in_tuser[0]),
    .in_ready(in_tready), .out_valid(out_tvalid), .out_ready(out_tready),
    .sts(sts), .cmd(cmd)
  );

  srp_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .in_steps(in_tdata), .cmd(cmd), .sts(sts),
    .out_data(out_tdata)
  );
endmodule
`default_nettype wire

// ===== bench/stepper_trapezoid_ramp_top_tb.sv =====
// Self-checking bench for stepper_trapezoid_ramp_top: start and compare-event items are checked
// against an in-bench ramp predictor or a table of expected results. Depends on srp_pkg and the RTL.
`timescale 1ns / 1ps
module stepper_trapezoid_ramp_top_tb;
  import srp_pkg::*;

  localparam int LIMIT_CYC = 2000000;
  localparam int SETTLE_CYC = 120;

  typedef struct packed {
    logic        dir;
    logic        fin;
    logic        mov;
    logic [31:0] pos;
    logic        took;
    logic [15:0] ivl;
  } ramp_out_t;

  typedef struct {
    logic        cmd;
    logic [31:0] steps;
    bit          typed;
    ramp_out_t   want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DataW-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutW-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  stepper_trapezoid_ramp_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of configuration and state
  logic [31:0] c_first, c_top, c_stt, c_acc, c_dec;
  logic [1:0]  p_phase;
  logic [31:0] p_dir, p_delay, p_idx, p_doff, p_dpt, p_done_cnt, p_rest, p_last;
  logic [31:0] p_half, p_pos, p_busy, p_fin, p_cruise;

  ramp_out_t pending_q[$];
  int errors = 0, accepted = 0, checked = 0, starts = 0, steps_seen = 0, finishes = 0;
  bit hold_req = 0;
  int cycles = 0;

  function automatic logic [31:0] div_or_ones(logic [31:0] a, logic [31:0] b);
    return (b == 0) ? 32'hFFFF_FFFF : a / b;
  endfunction

  function automatic logic [15:0] next_ramp_delay();
    logic [31:0] a, b, ma, mb, mq, mr;
    p_idx = p_idx + 1;
    a = 2 * p_delay + p_rest;
    b = 4 * p_idx + 1;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    mq = ma / mb;
    mr = ma % mb;
    p_rest = a[31] ? -mr : mr;
    return 16'(p_delay - ((a[31] != b[31]) ? -mq : mq));
  endfunction

  function automatic ramp_out_t predict_item(logic cmd, logic [31:0] raw);
    ramp_out_t r;
    logic [31:0] mag, top, lim, nd;
    logic took;
    took = 0;
    nd = 0;
    if (cmd == CMD_START) begin
      p_fin = 0;
      p_dir = raw[31];
      mag = raw[31] ? -raw : raw;
      if (mag == 1) begin
        p_idx = 32'hFFFF_FFFF;
        p_phase = PH_DECEL;
        p_delay = ONE_STEP_DELAY;
      end else if (mag != 0) begin
        top = (c_stt != 0) ? c_stt : 1;
        p_cruise = c_top;
        p_delay = c_first;
        lim = div_or_ones(mag * c_dec, c_acc + c_dec);
        if (lim == 0) lim = 1;
        if (lim <= top) p_doff = lim - mag;
        else p_doff = -div_or_ones(top * c_acc, c_dec);
        if (p_doff == 0) p_doff = 32'hFFFF_FFFF;
        p_dpt = mag + p_doff;
        if (p_delay <= p_cruise) begin
          p_delay = p_cruise;
          p_phase = PH_RUN;
        end else begin
          p_phase = PH_ACCEL;
        end
        p_idx = 0;
      end
      p_busy = 1;
      r.ivl = p_delay[15:0];
    end else begin
      r.ivl = p_delay[15:0];
      p_half ^= 1;
      if (p_half == 0) begin
        if (p_phase == PH_STOP) begin
          p_done_cnt = 0;
          p_rest = 0;
          p_busy = 0;
        end else begin
          p_done_cnt += 1;
          p_pos += p_dir[0] ? 32'hFFFF_FFFF : 32'd1;
          took = 1;
          case (p_phase)
            PH_ACCEL: begin
              nd = next_ramp_delay();
              if (p_done_cnt >= p_dpt) begin
                p_idx = p_doff;
                p_phase = PH_DECEL;
              end else if (nd <= p_cruise) begin
                p_last = nd;
                nd = {16'd0, p_cruise[15:0]};
                p_rest = 0;
                p_phase = PH_RUN;
              end
            end
            PH_RUN: begin
              nd = {16'd0, p_cruise[15:0]};
              if (p_done_cnt >= p_dpt) begin
                p_idx = p_doff;
                nd = p_last;
                p_phase = PH_DECEL;
              end
            end
            default: begin
              nd = next_ramp_delay();
              if (!p_idx[31]) begin
                p_phase = PH_STOP;
                p_fin = 1;
              end
            end
          endcase
        end
        p_delay = nd;
      end
    end
    r.took = took;
    r.pos = p_pos;
    r.mov = p_busy[0];
    r.fin = p_fin[0];
    r.dir = p_dir[0];
    return r;
  endfunction

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FIRST_DELAY: c_first = val & 32'hFFFF;
      REG_TOP_DELAY:   c_top = val & 32'hFFFF;
      REG_STEPS_TOP:   c_stt = val & 32'hFF_FFFF;
      REG_ACCEL:       c_acc = val & 32'hFFFF;
      default:         c_dec = val & 32'hFFFF;
    endcase
  endtask

  task automatic load_profile(logic [31:0] fd, logic [31:0] td, logic [31:0] stt,
                              logic [31:0] ar, logic [31:0] dr);
    wait (pending_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(REG_FIRST_DELAY, fd);
    write_reg(REG_TOP_DELAY, td);
    write_reg(REG_STEPS_TOP, stt);
    write_reg(REG_ACCEL, ar);
    write_reg(REG_DECEL, dr);
  endtask

  // sender keeps in_tvalid high across back-to-back items; lowered only for a gap or a pause
  int burst_left = 0;
  task automatic send_item(logic cmd, logic [31:0] steps, bit typed, ramp_out_t want);
    ramp_out_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= steps;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    accepted++;
    if (cmd == CMD_START) starts++;
    r = predict_item(cmd, steps);
    pending_q.push_back(typed ? want : r);
  endtask

  task automatic send_plain(logic cmd, logic [31:0] steps);
    send_item(cmd, steps, 0, '0);
  endtask

  task automatic pause_sender();
    @(posedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  always @(posedge clk) begin
    ramp_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(ramp_out_t)-1:0];
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (got.took) steps_seen++;
        if (got.fin && got.took) finishes++;
        if (got.ivl !== want.ivl) begin
          $error("compare_interval: expected %0d, got %0d", want.ivl, got.ivl); errors++;
        end
        if (got.took !== want.took) begin
          $error("step_taken: expected %0d, got %0d", want.took, got.took); errors++;
        end
        if (got.pos !== want.pos) begin
          $error("position: expected %0d, got %0d", $signed(want.pos), $signed(got.pos));
          errors++;
        end
        if (got.mov !== want.mov) begin
          $error("moving: expected %0d, got %0d", want.mov, got.mov); errors++;
        end
        if (got.fin !== want.fin) begin
          $error("move_finished: expected %0d, got %0d", want.fin, got.fin); errors++;
        end
        if (got.dir !== want.dir) begin
          $error("direction: expected %0d, got %0d", want.dir, got.dir); errors++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] random_move();
    logic [31:0] m;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) m = 1;
    else if (pick < 12) m = 0;
    else if (pick < 17) return $urandom();
    else if (pick < 20) m = $urandom_range(100, 400);
    else m = $urandom_range(2, 60);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic random_phase(int n_items);
    logic [31:0] mv, mag;
    int evs, sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_plain($urandom_range(0, 1), $urandom());
        sent++;
      end else begin
        mv = random_move();
        mag = mv[31] ? -mv : mv;
        send_plain(CMD_START, mv);
        evs = (mag > 70) ? 140 : 2 * mag + $urandom_range(0, 5);
        if ($urandom_range(0, 7) == 0) evs = $urandom_range(0, evs);
        for (int k = 0; k < evs; k++) send_plain(1'b1, $urandom());
        sent += evs + 1;
      end
    end
  endtask

  table_row_t dir_tab[] = '{
    '{1'b1, 32'h0,        1, '{0, 0, 0, 32'd0, 0, 16'd0}},
    '{1'b1, 32'hFFFFFFFF, 1, '{0, 0, 0, 32'd0, 0, 16'd0}},
    '{1'b0, 32'd1,        1, '{0, 0, 1, 32'd0, 0, 16'd1000}},
    '{1'b1, 32'h0,        1, '{0, 0, 1, 32'd0, 0, 16'd1000}},
    '{1'b1, 32'h0,        1, '{0, 1, 1, 32'd1, 1, 16'd1000}},
    '{1'b0, 32'hFFFFFFFF, 1, '{1, 0, 1, 32'd1, 0, 16'd1000}},
    '{1'b1, 32'h12345678, 0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b0, 32'd0,        0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b0, 32'h80000000, 0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b0, 32'h7FFFFFFF, 0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b1, 32'hAAAAAAAA, 0, '0},
    '{1'b0, 32'd5,        0, '0},
    '{1'b1, 32'h55555555, 0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b0, 32'hFFFFFFFD, 0, '0},
    '{1'b1, 32'h0,        0, '0},
    '{1'b1, 32'h0,        0, '0}
  };

  initial begin
    logic [31:0] fd;
    c_first = 1000; c_top = 100; c_stt = 1; c_acc = 100; c_dec = 100;
    p_phase = PH_STOP; p_dir = 0; p_delay = 0; p_idx = 0; p_doff = 0; p_dpt = 0;
    p_done_cnt = 0; p_rest = 0; p_last = 0; p_half = 0; p_pos = 0;
    p_busy = 0; p_fin = 0; p_cruise = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].cmd, dir_tab[i].steps, dir_tab[i].typed,
                                   dir_tab[i].want);
    pause_sender();

    load_profile(65535, 1, 24'hFFFFFF, 65535, 65535);
    hold_req = 1;
    random_phase(80);
    pause_sender();
    load_profile(1, 65535, 1, 1, 1);
    random_phase(40);
    pause_sender();
    load_profile(3000, 200, 0, 0, 0);
    random_phase(40);
    pause_sender();
    load_profile(3000, 200, 10, 500, 0);
    random_phase(40);
    for (int ph = 0; ph < 6; ph++) begin
      pause_sender();
      fd = $urandom_range(200, 6000);
      load_profile(fd, $urandom_range(20, fd), $urandom_range(1, 40),
                   $urandom_range(1, 3000), $urandom_range(1, 3000));
      random_phase(80);
    end
    pause_sender();

    wait (pending_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
    $display("Covered %0d items (%0d starts), %0d results checked, %0d steps, %0d moves ended.",
             accepted, starts, checked, steps_seen, finishes);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
